### rtl/fet_pkg.sv
// Shared types and constants for the frequent element threshold unit.
package fet_pkg;

  localparam int DATA_W      = 32;
  localparam int DIV_W       = 7;
  localparam logic [DIV_W-1:0] DIV_RESET = 7'd4;
  localparam int MAX_RESULTS = 64;
  localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     keep;
    logic                     last;
  } fet_item_t;

endpackage

### rtl/frequent_element_threshold_unit.sv
// Top level of the frequent element threshold unit.
// Loading: one transaction per cycle unless in_stall; each passes the two-entry queue.
// Search after the final item: one pass per distinct value plus one;
// input stalls once the queue holds two transactions of the next batch.
// A result waits for the next qualifying value or the end of the search: first result no
// sooner than two passes in. Synchronous reset clears control, divisor 4, memory undefined.
module frequent_element_threshold_unit #(
  parameter int MAX_ITEMS = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [fet_pkg::DIV_W-1:0]         cfg_wr_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [fet_pkg::DATA_W-1:0] value,
  input  logic                              end_of_batch,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [fet_pkg::DATA_W-1:0] result_value,
  output logic                              found,
  output logic                              last_result,
  output logic                              overflow
);
  import fet_pkg::*;

  fet_item_t push_item;
  fet_item_t pop_item;
  logic      push_valid;
  logic      push_ready;
  logic      pop_valid;
  logic      pop_ready;

  fet_front #(
    .MAX_ITEMS(MAX_ITEMS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .value       (value),
    .end_of_batch(end_of_batch),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_item   (push_item)
  );

  fet_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_item (push_item),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item)
  );

  fet_back #(
    .MAX_ITEMS(MAX_ITEMS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_item    (pop_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .result_value(result_value),
    .found       (found),
    .last_result (last_result),
    .overflow    (overflow)
  );

endmodule

### rtl/fet_queue.sv
// Two-entry transaction queue between the front and back parts.
module fet_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  fet_pkg::fet_item_t push_item,
  output logic             pop_valid,
  input  logic             pop_ready,
  output fet_pkg::fet_item_t pop_item
);
  import fet_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  fet_item_t     slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;
  logic          push;
  logic          pop;

  assign push_ready = (count != (PW + 1)'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/fet_front.sv
// Input side: accepts transactions and marks each as kept or dropped.
module fet_front #(
  parameter int MAX_ITEMS = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [fet_pkg::DATA_W-1:0] value,
  input  logic                              end_of_batch,
  output logic                              push_valid,
  input  logic                              push_ready,
  output fet_pkg::fet_item_t                push_item
);
  import fet_pkg::*;

  localparam int CW = $clog2(MAX_ITEMS + 1);

  logic [CW-1:0] batch_cnt;
  logic          full;
  logic          accept;

  assign full       = (batch_cnt == CW'(MAX_ITEMS));
  assign in_stall   = !push_ready;
  assign push_valid = in_valid;
  assign accept     = in_valid && push_ready;

  always_comb begin
    push_item.value = value;
    push_item.keep  = !full;
    push_item.last  = end_of_batch;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      batch_cnt <= '0;
    end else if (accept) begin
      if (end_of_batch) begin
        batch_cnt <= '0;
      end else if (!full) begin
        batch_cnt <= batch_cnt + 1'b1;
      end
    end
  end

endmodule

### rtl/fet_back.sv
// Back part: batch store, repeated min-above-previous scans, result register.
module fet_back #(
  parameter int MAX_ITEMS = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [fet_pkg::DIV_W-1:0]         cfg_wr_data,
  input  logic                              pop_valid,
  output logic                              pop_ready,
  input  fet_pkg::fet_item_t                pop_item,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [fet_pkg::DATA_W-1:0] result_value,
  output logic                              found,
  output logic                              last_result,
  output logic                              overflow
);
  import fet_pkg::*;

  localparam int AW    = $clog2(MAX_ITEMS);
  localparam int CW    = $clog2(MAX_ITEMS + 1);
  localparam int ACC_W = CW + DIV_W;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_DECIDE,
    ST_FINISH
  } state_t;

  state_t                     state;
  logic [DIV_W-1:0]           divisor;
  logic [CW-1:0]              occ;
  logic                       ovf;
  logic [CW-1:0]              rd_idx;
  logic                       rd_pend;
  logic signed [DATA_W-1:0]   store_mem [MAX_ITEMS];
  logic signed [DATA_W-1:0]   rd_data;
  logic signed [DATA_W-1:0]   prev;
  logic                       have_prev;
  logic signed [DATA_W-1:0]   cand;
  logic                       cand_valid;
  logic [ACC_W-1:0]           acc;
  logic signed [DATA_W-1:0]   pend_val;
  logic                       pend_valid;
  logic [RES_CNT_W-1:0]       nres;

  logic [ACC_W-1:0]           k_ext;
  logic                       out_free;
  logic                       emit;
  logic                       pop;
  logic                       issue;
  logic                       above_prev;
  logic                       better;
  logic                       same;
  logic                       hit;

  // count * k > n is the same test as count > floor(n / k)
  assign k_ext      = (divisor == '0) ? ACC_W'(1) : ACC_W'(divisor);
  assign out_free   = !out_valid || !out_stall;
  assign emit       = out_free && ((state == ST_FINISH) ||
                                   ((state == ST_DECIDE) && cand_valid && hit && pend_valid));
  assign pop_ready  = (state == ST_LOAD);
  assign pop        = pop_valid && pop_ready;
  assign issue      = (state == ST_SCAN) && (rd_idx != occ);
  assign above_prev = !have_prev || (rd_data > prev);
  assign better     = !cand_valid || (rd_data < cand);
  assign same       = cand_valid && (rd_data == cand);
  assign hit        = (acc > ACC_W'(occ));

  always_ff @(posedge clk) begin
    if (pop && pop_item.keep) begin
      store_mem[occ[AW-1:0]] <= pop_item.value;
    end
    rd_data <= store_mem[rd_idx[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      divisor    <= DIV_RESET;
      occ        <= '0;
      ovf        <= 1'b0;
      rd_pend    <= 1'b0;
      have_prev  <= 1'b0;
      cand_valid <= 1'b0;
      pend_valid <= 1'b0;
      nres       <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        divisor <= cfg_wr_data;
      end
      if (out_valid && !out_stall && !emit) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_LOAD: begin
          if (pop) begin
            if (pop_item.keep) begin
              occ <= occ + 1'b1;
            end else begin
              ovf <= 1'b1;
            end
            if (pop_item.last) begin
              state      <= ST_SCAN;
              rd_idx     <= '0;
              rd_pend    <= 1'b0;
              have_prev  <= 1'b0;
              cand_valid <= 1'b0;
              pend_valid <= 1'b0;
              nres       <= '0;
            end
          end
        end
        ST_SCAN: begin
          rd_pend <= issue;
          if (issue) begin
            rd_idx <= rd_idx + 1'b1;
          end
          if (rd_pend && above_prev) begin
            if (better) begin
              cand       <= rd_data;
              cand_valid <= 1'b1;
              acc        <= k_ext;
            end else if (same) begin
              acc <= acc + k_ext;
            end
          end
          if (!issue && !rd_pend) begin
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if (!cand_valid) begin
            state <= ST_FINISH;
          end else if (!hit) begin
            prev       <= cand;
            have_prev  <= 1'b1;
            cand_valid <= 1'b0;
            rd_idx     <= '0;
            state      <= ST_SCAN;
          end else if (!pend_valid || out_free) begin
            if (pend_valid) begin
              out_valid    <= 1'b1;
              result_value <= pend_val;
              found        <= 1'b1;
              last_result  <= 1'b0;
              overflow     <= ovf;
            end
            pend_val   <= cand;
            pend_valid <= 1'b1;
            nres       <= nres + 1'b1;
            prev       <= cand;
            have_prev  <= 1'b1;
            cand_valid <= 1'b0;
            rd_idx     <= '0;
            if (nres == RES_CNT_W'(MAX_RESULTS - 1)) begin
              state <= ST_FINISH;
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            result_value <= pend_valid ? pend_val : '0;
            found        <= pend_valid;
            last_result  <= 1'b1;
            overflow     <= ovf;
            occ          <= '0;
            ovf          <= 1'b0;
            pend_valid   <= 1'b0;
            state        <= ST_LOAD;
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_keep_has_room: assert property (@(posedge clk) disable iff (rst)
    (pop && pop_item.keep) |-> (occ < CW'(MAX_ITEMS)))
    else $error("kept transaction with store full");

  a_drop_only_full: assert property (@(posedge clk) disable iff (rst)
    (pop && !pop_item.keep) |-> (occ == CW'(MAX_ITEMS)))
    else $error("dropped transaction while store had room");

  a_finish_clears: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && out_free) |=>
      (state == ST_LOAD && occ == '0 && out_valid && last_result))
    else $error("batch end did not emit last result and clear");

  a_pend_counted: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> (nres != '0))
    else $error("pending result without result count");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (rd_idx <= occ))
    else $error("scan index past occupancy");
`endif

endmodule

### verif/testbench.sv
// Self-checking testbench: directed and random batches, randomized stalls, predicted threshold results.
`timescale 1ns / 100ps

module testbench;

  localparam int MAX_ITEMS   = 64;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct {
    int value;
    bit last;
  } element_t;

  typedef struct {
    int value;
    bit found;
    bit last;
    bit ovf;
  } frequent_t;

  logic                              clk;
  logic                              rst = 1'b1;
  logic                              cfg_wr_en = 1'b0;
  logic [fet_pkg::DIV_W-1:0]         cfg_wr_data = '0;
  logic                              in_valid = 1'b0;
  logic                              in_stall;
  logic signed [fet_pkg::DATA_W-1:0] value = '0;
  logic                              end_of_batch = 1'b0;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic signed [fet_pkg::DATA_W-1:0] result_value;
  logic                              found;
  logic                              last_result;
  logic                              overflow;

  element_t  pending_elements[$];
  frequent_t due_results[$];

  int held_sorted[MAX_ITEMS];
  int held_count = 0;
  bit batch_overflow = 1'b0;
  logic [fet_pkg::DIV_W-1:0] divisor_now = fet_pkg::DIV_RESET;

  bit steady = 1'b0;
  int send_gap = 0;
  int stall_left = 0;
  int errors = 0;
  int cycle_count = 0;
  int queued_total = 0;
  int elements_sent = 0;
  int batches_done = 0;
  int results_seen = 0;
  int overflow_batches = 0;
  int divisor_writes = 0;

  frequent_element_threshold_unit #(.MAX_ITEMS(MAX_ITEMS)) u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .value        (value),
    .end_of_batch (end_of_batch),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_value (result_value),
    .found        (found),
    .last_result  (last_result),
    .overflow     (overflow)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Sorted insert per element; on end of batch emit runs above floor(n/k).
  function automatic void predict_frequent(int v, bit eob);
    int pos;
    int i;
    int run;
    int k;
    int thr;
    int produced;
    frequent_t r;
    elements_sent++;
    if (held_count < MAX_ITEMS) begin
      pos = held_count;
      while (pos > 0 && held_sorted[pos-1] > v) begin
        held_sorted[pos] = held_sorted[pos-1];
        pos--;
      end
      held_sorted[pos] = v;
      held_count++;
    end else begin
      batch_overflow = 1'b1;
    end
    if (!eob) return;
    k = (divisor_now == 0) ? 1 : int'(divisor_now);
    thr = held_count / k;
    produced = 0;
    i = 0;
    while (i < held_count && produced < fet_pkg::MAX_RESULTS) begin
      run = 1;
      while (i + 1 < held_count && held_sorted[i+1] == held_sorted[i]) begin
        run++;
        i++;
      end
      if (run > thr) begin
        r.value = held_sorted[i];
        r.found = 1'b1;
        r.last = 1'b0;
        r.ovf = batch_overflow;
        due_results = {due_results, r};
        produced++;
      end
      i++;
    end
    if (produced == 0) begin
      r.value = 0;
      r.found = 1'b0;
      r.last = 1'b1;
      r.ovf = batch_overflow;
      due_results = {due_results, r};
    end else begin
      due_results[due_results.size()-1].last = 1'b1;
    end
    if (batch_overflow) overflow_batches++;
    batches_done++;
    held_count = 0;
    batch_overflow = 1'b0;
  endfunction

  // driver
  always @(posedge clk) begin
    element_t e;
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_frequent(value, end_of_batch);
        send_gap = pick_gap();
      end
      if (!(in_valid && in_stall)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_elements.size() != 0) begin
          e = pending_elements.pop_front();
          value <= e.value;
          end_of_batch <= e.last;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    frequent_t x;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (due_results.size() == 0) begin
          errors++;
          if (errors <= 20)
            $display("%0t: unexpected transaction value=%0d found=%0b last=%0b overflow=%0b",
                     $time, result_value, found, last_result, overflow);
        end else begin
          x = due_results.pop_front();
          if (result_value !== x.value || found !== x.found ||
              last_result !== x.last || overflow !== x.ovf) begin
            errors++;
            if (errors <= 20)
              $display(
                "%0t: mismatch expected %0d f=%0b l=%0b o=%0b actual %0d f=%0b l=%0b o=%0b",
                $time, x.value, x.found, x.last, x.ovf,
                result_value, found, last_result, overflow);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               due_results.size());
      $display("frequent_element_threshold_unit regression: fail");
      $finish;
    end
  end

  task automatic add_element(int v, bit eob);
    element_t e;
    e.value = v;
    e.last = eob;
    pending_elements = {pending_elements, e};
    queued_total++;
  endtask

  task automatic add_batch(int count);
    int pool[4];
    int pool_n;
    int v;
    pool_n = $urandom_range(1, 4);
    for (int j = 0; j < 4; j++) begin
      case ($urandom_range(0, 5))
        0: pool[j] = 32'sh8000_0000;
        1: pool[j] = 32'sh7fff_ffff;
        2: pool[j] = $urandom_range(0, 8) - 4;
        default: pool[j] = $urandom;
      endcase
    end
    for (int j = 0; j < count; j++) begin
      if ($urandom_range(0, 4) == 0) v = $urandom;
      else v = pool[$urandom_range(0, pool_n - 1)];
      add_element(v, j == count - 1);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (pending_elements.size() != 0 || in_valid || due_results.size() != 0)
      @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_divisor(logic [fet_pkg::DIV_W-1:0] d);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= d;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    divisor_now = d;
    divisor_writes++;
  endtask

  initial begin
    logic [fet_pkg::DIV_W-1:0] div_plan[11];
    int phase;
    int nb;
    int sz;
    div_plan = '{7'd0, 7'd127, 7'd3, 7'd2, 7'd64, 7'd5, 7'd1, 7'd4, 7'd8, 7'd3, 7'd2};
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed, reset divisor of 4
    add_element(32'sh8000_0000, 1'b1);
    add_element(32'sh7fff_ffff, 1'b0);
    add_element(-1, 1'b0);
    add_element(0, 1'b0);
    add_element(32'sh7fff_ffff, 1'b1);
    add_element(1, 1'b0);
    add_element(2, 1'b0);
    add_element(3, 1'b0);
    add_element(4, 1'b1);
    wait_drained();
    set_divisor(7'd1);
    add_element(5, 1'b0);
    add_element(5, 1'b0);
    add_element(5, 1'b0);
    add_element(6, 1'b1);
    add_element(7, 1'b0);
    add_element(1, 1'b1);
    wait_drained();
    set_divisor(7'd64);
    add_element(3, 1'b0);
    add_element(-3, 1'b0);
    add_element(3, 1'b1);
    wait_drained();
    set_divisor(7'd2);
    add_element(9, 1'b0);
    add_element(-9, 1'b0);
    add_element(9, 1'b1);
    add_element(-9, 1'b0);
    add_element(-9, 1'b0);
    add_element(8, 1'b0);
    add_element(8, 1'b1);
    wait_drained();

    // random phases
    phase = 0;
    while (queued_total < 150 || phase < 4) begin
      set_divisor(div_plan[phase % 11]);
      steady = ($urandom_range(0, 3) == 0);
      nb = $urandom_range(1, 3);
      for (int b = 0; b < nb; b++) begin
        if (phase == 1 && b == 0) sz = 70;
        else if ($urandom_range(0, 9) == 0) sz = $urandom_range(13, 40);
        else sz = $urandom_range(1, 12);
        add_batch(sz);
      end
      wait_drained();
      phase++;
    end
    steady = 1'b0;
    repeat (20) @(posedge clk);

    if (due_results.size() != 0) begin
      errors++;
      $display("%0t: %0d expected results never arrived", $time, due_results.size());
    end
    $display("run covered %0d elements in %0d batches (%0d overflowing), %0d results checked",
             elements_sent, batches_done, overflow_batches, results_seen);
    $display("divisor written %0d times, %0d mismatches", divisor_writes, errors);
    if (errors == 0) begin
      $display("frequent_element_threshold_unit regression: pass");
    end else begin
      $display("frequent_element_threshold_unit regression: fail");
    end
    $finish;
  end

endmodule

### frequent_element_threshold_unit.f
rtl/fet_pkg.sv
rtl/fet_queue.sv
rtl/fet_front.sv
rtl/fet_back.sv
rtl/frequent_element_threshold_unit.sv
verif/testbench.sv
